// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge, idle during reset
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Non-overlapping implication, idle during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ===== src/khtqp_pkg.sv =====
// ----------------------------------------------------------------------------
// khtqp_pkg: shared types and constants of the keyword hash table
// Beat types, status codes, function codes and controller commands.
// ----------------------------------------------------------------------------
package khtqp_pkg;
   localparam int TABLE_SIZE_DEF = 127;
   localparam int MAX_LEN_DEF    = 16;
   localparam int HASH_MULT      = 31;

   localparam logic [1:0] FUNC_LOOKUP = 2'd0;
   localparam logic [1:0] FUNC_INSERT = 2'd1;
   localparam logic [1:0] FUNC_CLEAR  = 2'd2;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_NOT_FOUND = 3'd1;
   localparam logic [2:0] ST_FULL      = 3'd2;
   localparam logic [2:0] ST_TOO_LONG  = 3'd3;
   localparam logic [2:0] ST_CLEARED   = 3'd4;

   typedef struct packed {
      logic [1:0] func;
      logic [7:0] ch;
      logic       last;
      logic [7:0] token_in;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [7:0] token_out;
      logic [6:0] slot;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic take_char;   // hash and buffer req char
      logic word_clr;    // drop word in progress
      logic tab_clr;     // empty all slots
      logic probe_start; // k = 0 at home slot
      logic probe_next;  // advance k
      logic rd_slot;     // issue slot read
      logic cmp_start;   // start char compare
      logic cmp_next;    // advance char index
      logic wr_slot;     // write key meta and valid
      logic wr_char;     // write one key char
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic too_long;
      logic slot_valid;   // valid bit of current probe slot
      logic probe_done;   // k reached last probe
      logic len_match;    // stored length equals word length
      logic cmp_last;     // char index at final char
      logic char_eq;      // stored char equals buffered char
      logic word_empty;   // no chars to write or compare
   } sts_type;
endpackage

// ===== src/khtqp_ram.sv =====
// ----------------------------------------------------------------------------
// khtqp_ram: generic single-port-write RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module khtqp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

// ===== src/khtqp_datapath.sv =====
// ----------------------------------------------------------------------------
// khtqp_datapath: word buffer, hash, probe sequencer and slot storage
// Holds valid bits in flops, keys, lengths and tokens in RAMs.
// ----------------------------------------------------------------------------
module khtqp_datapath
   import khtqp_pkg::*;
#(
   parameter int TABLE_SIZE = TABLE_SIZE_DEF,
   parameter int MAX_LEN    = MAX_LEN_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  req_type req,
   input  cmd_type cmd,
   output sts_type sts,
   output logic [6:0] cur_slot,
   output logic [7:0] cur_token
);
   localparam int SW = $clog2(TABLE_SIZE);
   localparam int LW = $clog2(MAX_LEN + 1);
   localparam int CW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int KW = $clog2(TABLE_SIZE + 1);
   localparam int AW = $clog2(TABLE_SIZE * MAX_LEN);
   localparam int HN = SW + 7;
   localparam logic [SW:0] TS = (SW + 1)'(TABLE_SIZE);
   localparam logic [HN-1:0] TSN   = HN'(TABLE_SIZE);
   localparam logic [HN-1:0] RECIP = HN'((2 ** HN) / TABLE_SIZE);

   logic [LW-1:0] len_ff, len_in;
   logic          tl_ff, tl_in;
   logic [SW-1:0] hash_ff, hash_in;
   logic [TABLE_SIZE-1:0] valid_ff;
   logic [SW-1:0] slot_ff, slot_in;
   logic [KW-1:0] k_ff, k_in;
   logic [SW-1:0] step_ff, step_in; // 2k+1 mod TS
   logic [CW-1:0] ci_ff, ci_in;
   logic [7:0]    tok_ff;
   logic [7:0]    key_rd;
   logic [LW-1:0] klen_rd;
   logic [7:0]    tok_rd;
   logic [7:0]    wchar;
   logic [SW+5:0] hmul;
   logic [HN-1:0] hsum;
   logic [2*HN-1:0] hprod;
   logic [HN-1:0] hquo, hrem;
   logic [SW:0]   nsum, nstep;

   // word buffer holds the characters of the word in progress
   logic [7:0] wbyte_ff [MAX_LEN];

   assign wchar = wbyte_ff[ci_ff];

   always_comb begin
      hmul    = (SW + 6)'(hash_ff) * (SW + 6)'(HASH_MULT);
      hsum    = HN'(hmul) + HN'(req.ch);
      // reduce by reciprocal multiply; the quotient is exact or one low,
      // so one compare and subtract finishes the remainder
      hprod   = (2 * HN)'(hsum) * (2 * HN)'(RECIP);
      hquo    = hprod[2*HN-1:HN];
      hrem    = hsum - HN'(hquo * TSN);
      hash_in = (hrem >= TSN) ? SW'(hrem - TSN) : SW'(hrem);
      len_in  = len_ff;
      tl_in   = tl_ff;
      if (cmd.take_char) begin
         if (len_ff < LW'(MAX_LEN)) begin
            len_in = len_ff + 1'b1;
         end else begin
            tl_in = 1'b1;
         end
      end else begin
         hash_in = hash_ff;
      end
      if (cmd.word_clr) begin
         len_in  = '0;
         tl_in   = 1'b0;
         hash_in = '0;
      end
      nsum    = (SW + 1)'(slot_ff) + (SW + 1)'(step_ff);
      nstep   = (SW + 1)'(step_ff) + (SW + 1)'(2);
      slot_in = slot_ff;
      step_in = step_ff;
      k_in    = k_ff;
      if (cmd.probe_start) begin
         // home slot takes the hash including the last character
         slot_in = hash_in;
         step_in = SW'(1 % TABLE_SIZE);
         k_in    = '0;
      end else if (cmd.probe_next) begin
         slot_in = (nsum >= TS) ? SW'(nsum - TS) : SW'(nsum);
         step_in = (nstep >= TS) ? SW'(nstep - TS) : SW'(nstep);
         k_in    = k_ff + 1'b1;
      end
      ci_in = ci_ff;
      if (cmd.cmp_start) begin
         ci_in = '0;
      end else if (cmd.cmp_next) begin
         ci_in = ci_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff   <= '0;
         tl_ff    <= 1'b0;
         hash_ff  <= '0;
         valid_ff <= '0;
         k_ff     <= '0;
         ci_ff    <= '0;
      end else begin
         len_ff  <= len_in;
         tl_ff   <= tl_in;
         hash_ff <= hash_in;
         k_ff    <= k_in;
         ci_ff   <= ci_in;
         if (cmd.tab_clr) begin
            valid_ff <= '0;
         end else if (cmd.wr_slot) begin
            valid_ff[slot_ff] <= 1'b1;
         end
      end
      slot_ff <= slot_in;
      step_ff <= step_in;
      // hold the token of the last character for the slot write
      if (cmd.probe_start) begin
         tok_ff <= req.token_in;
      end
      if (cmd.take_char && len_ff < LW'(MAX_LEN)) begin
         wbyte_ff[CW'(len_ff)] <= req.ch;
      end
   end

   khtqp_ram #(.WIDTH(8), .DEPTH(TABLE_SIZE * MAX_LEN)) u_keys (
      .clock   (clock),
      .wr_en   (cmd.wr_char),
      .wr_addr (AW'(slot_ff * MAX_LEN + ci_ff)),
      .wr_data (wchar),
      .rd_addr (AW'(slot_ff * MAX_LEN + ci_ff)),
      .rd_data (key_rd)
   );

   khtqp_ram #(.WIDTH(LW), .DEPTH(TABLE_SIZE)) u_klen (
      .clock   (clock),
      .wr_en   (cmd.wr_slot),
      .wr_addr (slot_ff),
      .wr_data (len_ff),
      .rd_addr (slot_ff),
      .rd_data (klen_rd)
   );

   khtqp_ram #(.WIDTH(8), .DEPTH(TABLE_SIZE)) u_tok (
      .clock   (clock),
      .wr_en   (cmd.wr_slot),
      .wr_addr (slot_ff),
      .wr_data (tok_ff),
      .rd_addr (slot_ff),
      .rd_data (tok_rd)
   );

   assign sts.too_long   = tl_ff;
   assign sts.slot_valid = valid_ff[slot_ff];
   assign sts.probe_done = (k_ff == KW'(TABLE_SIZE - 1));
   assign sts.len_match  = (klen_rd == len_ff);
   assign sts.cmp_last   = ((LW'(ci_ff) + 1'b1) == len_ff);
   assign sts.char_eq    = (key_rd == wchar);
   assign sts.word_empty = (len_ff == '0);
   assign cur_slot       = 7'(slot_ff);
   assign cur_token      = tok_rd;
endmodule

// ===== src/khtqp_ctrl.sv =====
// ----------------------------------------------------------------------------
// khtqp_ctrl: controller state machine of the keyword hash table
// Sequences character intake, probe walk, key compare and key write.
// ----------------------------------------------------------------------------
module khtqp_ctrl
   import khtqp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp,
   output cmd_type    cmd,
   input  sts_type    sts,
   input  logic [6:0] cur_slot,
   input  logic [7:0] cur_token
);
   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_PROBE = 7'b0000010, // check valid, issue reads
      S_META  = 7'b0000100, // wait for length read
      S_CMP   = 7'b0001000, // compare one stored char with the buffered char
      S_WRITE = 7'b0010000, // copy word chars into slot
      S_NEXT  = 7'b0100000, // advance probe
      S_RESP  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic      ins_ff, ins_in;
   rsp_type   rsp_ff, rsp_in;
   logic      acc;

   assign req_ready = (state_ff == S_IDLE);
   assign acc       = req_valid && req_ready;
   assign rsp_valid = (state_ff == S_RESP);
   assign rsp       = rsp_ff;

   always_comb begin
      state_in = state_ff;
      ins_in   = ins_ff;
      rsp_in   = rsp_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (acc) begin
               if (req.func == FUNC_CLEAR) begin
                  cmd.tab_clr  = 1'b1;
                  cmd.word_clr = 1'b1;
                  rsp_in       = '{ST_CLEARED, 8'd0, 7'd0};
                  state_in     = S_RESP;
               end else if (req.func inside {FUNC_LOOKUP, FUNC_INSERT}) begin
                  cmd.take_char = 1'b1;
                  if (req.last) begin
                     ins_in          = (req.func == FUNC_INSERT);
                     cmd.probe_start = 1'b1;
                     state_in        = S_PROBE;
                  end
               end
            end
         end
         S_PROBE: begin
            if (sts.too_long) begin
               rsp_in   = '{ST_TOO_LONG, 8'd0, 7'd0};
               cmd.word_clr = 1'b1;
               state_in = S_RESP;
            end else if (!sts.slot_valid) begin
               if (ins_ff) begin
                  cmd.wr_slot   = 1'b1;
                  cmd.cmp_start = 1'b1;
                  rsp_in        = '{ST_OK, 8'd0, cur_slot};
                  state_in      = sts.word_empty ? S_RESP : S_WRITE;
                  if (sts.word_empty) cmd.word_clr = 1'b1;
               end else begin
                  rsp_in       = '{ST_NOT_FOUND, 8'd0, 7'd0};
                  cmd.word_clr = 1'b1;
                  state_in     = S_RESP;
               end
            end else if (ins_ff) begin
               state_in = S_NEXT;
            end else begin
               cmd.cmp_start = 1'b1;
               state_in      = S_META;
            end
         end
         S_META: begin
            if (!sts.len_match) begin
               state_in = S_NEXT;
            end else if (sts.word_empty) begin
               rsp_in       = '{ST_OK, cur_token, cur_slot};
               cmd.word_clr = 1'b1;
               state_in     = S_RESP;
            end else begin
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            if (!sts.char_eq) begin
               state_in = S_NEXT;
            end else if (sts.cmp_last) begin
               rsp_in       = '{ST_OK, cur_token, cur_slot};
               cmd.word_clr = 1'b1;
               state_in     = S_RESP;
            end else begin
               cmd.cmp_next = 1'b1;
               state_in     = S_META;
            end
         end
         S_WRITE: begin
            cmd.wr_char = 1'b1;
            if (sts.cmp_last) begin
               cmd.word_clr = 1'b1;
               state_in     = S_RESP;
            end else begin
               cmd.cmp_next = 1'b1;
            end
         end
         S_NEXT: begin
            if (sts.probe_done) begin
               rsp_in       = ins_ff ? rsp_type'{ST_FULL, 8'd0, 7'd0}
                                     : rsp_type'{ST_NOT_FOUND, 8'd0, 7'd0};
               cmd.word_clr = 1'b1;
               state_in     = S_RESP;
            end else begin
               cmd.probe_next = 1'b1;
               state_in       = S_PROBE;
            end
         end
         S_RESP: begin
            if (rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      ins_ff <= ins_in;
      rsp_ff <= rsp_in;
   end
endmodule

// ===== src/keyword_hash_table_quadratic_probe.sv =====
// ----------------------------------------------------------------------------
// keyword_hash_table_quadratic_probe: keyword table with quadratic probing
// Top level joining the controller and the datapath.
// ----------------------------------------------------------------------------
// A word arrives one character per req beat; middle characters are taken back
// to back, one per cycle. The last character, or a clear, drops req_ready
// until its rsp beat is taken. A clear answers on the next cycle. On the last
// character the block walks the slots home + k*k: an insert passes S_PROBE
// and S_NEXT per occupied slot, a lookup whose stored length differs also
// S_META; a lookup compares each character in S_META then S_CMP, as the key
// RAM returns one registered character per read, and an insert copies one
// character per cycle. One rsp beat follows each last character or clear.
// Valid bits sit in flops and clear at reset and on a clear beat.
module keyword_hash_table_quadratic_probe
   import khtqp_pkg::*;
#(
   parameter int TABLE_SIZE = TABLE_SIZE_DEF,
   parameter int MAX_LEN    = MAX_LEN_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);
   cmd_type    cmd;
   sts_type    sts;
   logic [6:0] cur_slot;
   logic [7:0] cur_token;

   // hold control in the controller, storage in the datapath
   khtqp_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .req(req_data),
      .rsp_valid, .rsp_ready, .rsp(rsp_data), .cmd, .sts, .cur_slot, .cur_token
   );

   khtqp_datapath #(.TABLE_SIZE(TABLE_SIZE), .MAX_LEN(MAX_LEN)) u_dp (
      .clock, .reset, .req(req_data), .cmd, .sts, .cur_slot, .cur_token
   );
endmodule

// ===== src/khtqp_checker.sv =====
// ----------------------------------------------------------------------------
// khtqp_checker: port-level checks of the keyword hash table
// Bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module khtqp_checker
   import khtqp_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);
   `ASSERT_IMPL(a_no_ready_with_rsp, clock, reset, rsp_valid, !req_ready, "ready while rsp pending")
   `ASSERT_NEXT(a_clear_resp, clock, reset, req_valid && req_ready && req_data.func == FUNC_CLEAR, rsp_valid && rsp_data.status == ST_CLEARED, "clear gave no beat")
   `ASSERT_NEXT(a_mid_no_rsp, clock, reset, req_valid && req_ready && !req_data.last && req_data.func != FUNC_CLEAR, !rsp_valid, "middle char gave beat")
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "rsp dropped")
endmodule

bind keyword_hash_table_quadratic_probe khtqp_checker u_chk (.*);

// ===== bench/tb_keyword_hash_table_quadratic_probe.sv =====
// ----------------------------------------------------------------------------
// Keyword hash table testbench
// Drives words one character per beat through the request channel, predicts
// every status, token and slot with an in-bench copy of the table, and checks
// each response beat in order. Idling and back-pressure vary by phase.
// ----------------------------------------------------------------------------
module tb_keyword_hash_table_quadratic_probe;
   import khtqp_pkg::*;

   localparam int TSIZE = TABLE_SIZE_DEF;
   localparam int MLEN  = MAX_LEN_DEF;
   localparam logic [1:0] FUNC_SPARE = 2'd3;

   // Model of the table and the word in progress
   class keyword_scoreboard;
      logic [7:0] word_chars[MLEN];
      int         word_len;
      bit         word_over;
      int         word_hash;
      bit         used[TSIZE];
      logic [7:0] key_chars[TSIZE][MLEN];
      int         key_len[TSIZE];
      logic [7:0] key_token[TSIZE];
      rsp_type    pending[$];
      int         errors;
      int         checked;
      int         n_found, n_miss, n_full, n_long;

      function void drop_word();
         word_len  = 0;
         word_over = 0;
         word_hash = 0;
      endfunction

      function void init();
         drop_word();
         foreach (used[i]) used[i] = 0;
         errors = 0;
         checked = 0;
      endfunction

      function bit key_equal(int s);
         if (key_len[s] != word_len) return 0;
         for (int i = 0; i < word_len; i++)
            if (key_chars[s][i] != word_chars[i]) return 0;
         return 1;
      endfunction

      // Note one accepted request beat and queue any response it causes
      function void note_request(req_type r);
         rsp_type o;
         int      s;
         o = '0;
         if (r.func == FUNC_SPARE) return;
         if (r.func == FUNC_CLEAR) begin
            foreach (used[i]) used[i] = 0;
            drop_word();
            o.status = ST_CLEARED;
            pending.push_back(o);
            return;
         end
         word_hash = (word_hash * HASH_MULT + r.ch) % TSIZE;
         if (word_len < MLEN) begin
            word_chars[word_len] = r.ch;
            word_len++;
         end else begin
            word_over = 1;
         end
         if (!r.last) return;
         if (word_over) begin
            o.status = ST_TOO_LONG;
            n_long++;
         end else if (r.func == FUNC_LOOKUP) begin
            o.status = ST_NOT_FOUND;
            for (int k = 0; k < TSIZE; k++) begin
               s = (word_hash + k * k) % TSIZE;
               if (!used[s]) break;
               if (key_equal(s)) begin
                  o.status = ST_OK;
                  o.token_out = key_token[s];
                  o.slot = s[6:0];
                  break;
               end
            end
            if (o.status == ST_OK) n_found++; else n_miss++;
         end else begin
            o.status = ST_FULL;
            for (int k = 0; k < TSIZE; k++) begin
               s = (word_hash + k * k) % TSIZE;
               if (!used[s]) begin
                  used[s] = 1;
                  for (int i = 0; i < word_len; i++) key_chars[s][i] = word_chars[i];
                  key_len[s] = word_len;
                  key_token[s] = r.token_in;
                  o.status = ST_OK;
                  o.slot = s[6:0];
                  break;
               end
            end
            if (o.status == ST_FULL) n_full++;
         end
         pending.push_back(o);
         drop_word();
      endfunction

      // Compare one response beat with the oldest prediction
      function void check_response(rsp_type a);
         rsp_type e;
         checked++;
         if (pending.size() == 0) begin
            $error("response beat with nothing expected: %p", a);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (a.status !== e.status) begin
            $error("status: expected %0d, actual %0d", e.status, a.status);
            errors++;
         end
         if (a.token_out !== e.token_out) begin
            $error("token_out: expected %0d, actual %0d", e.token_out, a.token_out);
            errors++;
         end
         if (a.slot !== e.slot) begin
            $error("slot: expected %0d, actual %0d", e.slot, a.slot);
            errors++;
         end
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   keyword_scoreboard table_model;
   int  send_idle_pct;
   int  recv_stall_pct;
   bit  hold_off;
   int  beats_sent;

   // Small vocabulary so that lookups often hit and slots collide
   logic [7:0] vocab[8][MLEN];
   int         vocab_len[8];

   keyword_hash_table_quadratic_probe i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   // Generous ceiling on the whole run
   initial begin
      #4000000;
      $display("*** FAILED ***");
      $finish;
   end

   // Send one beat: idle first at random, then hold valid until accepted.
   // Valid is left high afterwards; the caller drops it when it stops sending.
   task automatic send_beat(input logic [1:0] f, input logic [7:0] c, input bit l,
                            input logic [7:0] t);
      req_type r;
      r.func = f;
      r.ch = c;
      r.last = l;
      r.token_in = t;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      table_model.note_request(r);
      beats_sent++;
   endtask

   // Send a whole word; its last character carries the function code
   task automatic send_word(input logic [1:0] f, input int n, input logic [7:0] w[],
                            input logic [7:0] t);
      for (int i = 0; i < n; i++) begin
         if (i == n - 1)
            send_beat(f, w[i], 1'b1, t);
         else
            send_beat(($urandom_range(3) == 0) ? ~f & 2'b01 : f, w[i], 1'b0, t);
      end
   endtask

   task automatic send_vocab(input logic [1:0] f, input int v, input logic [7:0] t);
      logic [7:0] w[];
      w = new[vocab_len[v]];
      for (int i = 0; i < vocab_len[v]; i++) w[i] = vocab[v][i];
      send_word(f, vocab_len[v], w, t);
   endtask

   task automatic send_random_word(input logic [1:0] f, input int n);
      logic [7:0] w[];
      w = new[n];
      foreach (w[i]) w[i] = 8'($urandom_range(255));
      send_word(f, n, w, 8'($urandom_range(255)));
   endtask

   // Wait until every predicted response has come, then let the block settle
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (table_model.pending.size() != 0) @(posedge clock);
      repeat (600) @(posedge clock);
   endtask

   // One random item: mostly vocabulary words, some noise
   task automatic random_item();
      int pick;
      pick = $urandom_range(99);
      if (pick < 40)
         send_vocab(FUNC_LOOKUP, $urandom_range(7), 8'd0);
      else if (pick < 65)
         send_vocab(FUNC_INSERT, $urandom_range(7), 8'($urandom_range(255)));
      else if (pick < 80)
         send_random_word(2'($urandom_range(1)), $urandom_range(1, 6));
      else if (pick < 86)
         send_random_word(2'($urandom_range(1)), $urandom_range(15, 20));
      else if (pick < 90)
         send_beat(FUNC_CLEAR, 8'($urandom_range(255)), 1'($urandom_range(1)),
                   8'($urandom_range(255)));
      else if (pick < 95)
         send_beat(FUNC_SPARE, 8'($urandom_range(255)), 1'($urandom_range(1)),
                   8'($urandom_range(255)));
      else
         send_random_word(FUNC_INSERT, 1);
   endtask

   // Response side: stall at random, or hold off completely when asked
   initial begin
      rsp_ready <= 1'b0;
      @(posedge clock);
      forever begin
         rsp_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
         @(posedge clock);
         if (rsp_valid && rsp_ready) table_model.check_response(rsp_data);
      end
   end

   // Long hold-off counted here while the sender keeps offering beats
   task automatic stall_receiver(input int cycles);
      hold_off = 1;
      repeat (cycles) @(posedge clock);
      hold_off = 0;
   endtask

   initial begin
      logic [7:0] w[];
      table_model = new();
      table_model.init();
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_off = 0;
      beats_sent = 0;
      for (int v = 0; v < 8; v++) begin
         vocab_len[v] = (v == 7) ? MLEN : $urandom_range(1, 6);
         for (int i = 0; i < MLEN; i++) vocab[v][i] = 8'($urandom_range(255));
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: miss on empty table, insert, hit, extremes, too long, spare, clear
      w = new[MLEN];
      foreach (w[i]) w[i] = 8'hFF;
      send_beat(FUNC_LOOKUP, 8'h00, 1'b1, 8'h00);
      send_beat(FUNC_INSERT, 8'h00, 1'b1, 8'hFF);
      send_beat(FUNC_LOOKUP, 8'h00, 1'b1, 8'h00);
      send_word(FUNC_INSERT, MLEN, w, 8'h00);
      send_word(FUNC_LOOKUP, MLEN, w, 8'h00);
      send_beat(FUNC_INSERT, 8'h00, 1'b1, 8'hA5);   // duplicate placed further on
      send_beat(FUNC_LOOKUP, 8'h00, 1'b1, 8'h00);
      w = new[MLEN + 1];
      foreach (w[i]) w[i] = 8'h55;
      send_word(FUNC_INSERT, MLEN + 1, w, 8'h11);
      send_beat(FUNC_SPARE, 8'hFF, 1'b1, 8'hFF);
      send_beat(FUNC_LOOKUP, 8'h41, 1'b0, 8'h00);
      send_beat(FUNC_CLEAR, 8'hAA, 1'b0, 8'h00);    // drops the word in progress
      send_beat(FUNC_LOOKUP, 8'h00, 1'b1, 8'h00);
      send_beat(FUNC_CLEAR, 8'h00, 1'b1, 8'hFF);
      drain();

      // Fill the table to the brim: one-character inserts probe until full
      for (int i = 0; i < TSIZE + 4; i++) send_beat(FUNC_INSERT, i[7:0], 1'b1, i[7:0]);
      for (int i = 0; i < 8; i++) send_beat(FUNC_LOOKUP, i[7:0] + 8'd120, 1'b1, 8'h00);
      send_beat(FUNC_LOOKUP, 8'hC3, 1'b1, 8'h00);   // miss walks a full table
      send_beat(FUNC_CLEAR, 8'h00, 1'b0, 8'h00);
      drain();

      // Random phases of idling
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
            default: begin send_idle_pct = 6; recv_stall_pct = 6; end
         endcase
         for (int n = 0; n < 70; n++) random_item();
         if (ph == 1) begin
            // sender pauses until everything has come back
            req_valid <= 1'b0;
            @(posedge clock);
            while (table_model.pending.size() != 0) @(posedge clock);
         end
      end

      // Back-pressure: receiver holds off while the sender keeps going
      send_idle_pct = 0;
      recv_stall_pct = 0;
      fork
         stall_receiver(800);
         begin
            for (int n = 0; n < 30; n++) random_item();
            req_valid <= 1'b0;
         end
      join
      for (int n = 0; n < 70; n++) random_item();
      drain();

      $display("Sent %0d request beats, checked %0d responses.", beats_sent,
               table_model.checked);
      $display("Hits %0d, misses %0d, full %0d, too long %0d.", table_model.n_found,
               table_model.n_miss, table_model.n_full, table_model.n_long);
      if (table_model.errors == 0 && table_model.pending.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end
endmodule

// ===== sim.f =====
+incdir+src
src/khtqp_pkg.sv
src/khtqp_ram.sv
src/khtqp_datapath.sv
src/khtqp_ctrl.sv
src/keyword_hash_table_quadratic_probe.sv
src/khtqp_checker.sv
bench/tb_keyword_hash_table_quadratic_probe.sv
